// ===== rtl/core/tlic_pkg.sv =====
package tlic_pkg;

  localparam int TAG_W    = 32;
  localparam int L1_AGE_W = 3;
  localparam int L2_AGE_W = 4;

  localparam logic [2:0] CFG_OFFSET_BITS  = 3'd0;
  localparam logic [2:0] CFG_L1_SIZE_BITS = 3'd1;
  localparam logic [2:0] CFG_L1_WAY_BITS  = 3'd2;
  localparam logic [2:0] CFG_L2_SIZE_BITS = 3'd3;
  localparam logic [2:0] CFG_L2_WAY_BITS  = 3'd4;

  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic [31:0] address;
    logic        cmd;
  } in_item_t;

  typedef struct packed {
    logic l1_hit;
    logic l2_hit;
    logic l1_dirty_writeback;
    logic l2_valid_eviction;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic fill;
    logic inval;
    logic dirty_we;
    logic touch;
  } lvl_op_t;

  typedef struct packed {
    logic             hit;
    logic             vic_valid;
    logic             vic_dirty;
    logic [TAG_W-1:0] vic_tag;
  } lvl_st_t;

  typedef struct packed {
    logic    accept;
    logic    sx1_go;
    logic    sx1_key_old;
    logic    sx2_go;
    logic    sx2_key_vb;
    logic    cap_s1;
    logic    l1_rd;
    logic    l1_rd_s1;
    logic    l1_key_old;
    lvl_op_t l1_op;
    logic    l2_rd;
    logic    l2_key_vb;
    lvl_op_t l2_op;
    logic    set_h2;
    logic    set_ev;
    logic    set_wb;
    logic    finish;
    logic    finish_hit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    sx1_done;
    logic    sx2_done;
    lvl_st_t l1;
    lvl_st_t l2;
  } ctrl_st_t;

endpackage

// ===== rtl/core/two_level_inclusive_lru_cache.sv =====
// Tag and LRU tracker for a two-level inclusive set-associative cache.
// Input: pulse start with in_item (byte address, cmd 0 read / 1 write)
// while busy is low; the item is taken on that edge and busy rises.
// Output: one item per access on out_item, flagged by out_valid for a
// single cycle; it must be captured then, there is no backpressure.
// An access runs as a sequence of set index computations and row reads
// and writes on the L1 and L2 set memories. Each set index is a registered
// mask of the block address, or, when a set count is not a power of two,
// a remainder by reciprocal multiply, registered in a pipeline. One access
// at a time; the next start may come in the cycle out_valid is high.
// Config: cfg_wr_en, cfg_index, cfg_wdata write one geometry register
// per cycle; write only while idle, and reset after a geometry change.
// Reset: synchronous, rst_n low. All lines invalid and clean, ages set
// to way order, geometry to its defaults; no clearing pass is needed.
module two_level_inclusive_lru_cache import tlic_pkg::*; #(
  parameter int FIRST_MAX_SETS  = 64,
  parameter int FIRST_MAX_WAYS  = 8,
  parameter int SECOND_MAX_SETS = 256,
  parameter int SECOND_MAX_WAYS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  logic [3:0] offset_bits_r;
  logic [4:0] l1_size_bits_r;
  logic [1:0] l1_way_bits_r;
  logic [4:0] l2_size_bits_r;
  logic [2:0] l2_way_bits_r;

  ctrl_cmd_t cmd;
  ctrl_st_t  st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r  <= 4'd4;
      l1_size_bits_r <= 5'd10;
      l1_way_bits_r  <= 2'd2;
      l2_size_bits_r <= 5'd14;
      l2_way_bits_r  <= 3'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS:  offset_bits_r  <= cfg_wdata[3:0];
        CFG_L1_SIZE_BITS: l1_size_bits_r <= cfg_wdata;
        CFG_L1_WAY_BITS:  l1_way_bits_r  <= cfg_wdata[1:0];
        CFG_L2_SIZE_BITS: l2_size_bits_r <= cfg_wdata;
        CFG_L2_WAY_BITS:  l2_way_bits_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  tlic_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  tlic_dp #(
    .L1_SETS (FIRST_MAX_SETS),
    .L1_WAYS (FIRST_MAX_WAYS),
    .L2_SETS (SECOND_MAX_SETS),
    .L2_WAYS (SECOND_MAX_WAYS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_item),
    .offset_bits  (offset_bits_r),
    .l1_size_bits (l1_size_bits_r),
    .l1_way_bits  (l1_way_bits_r),
    .l2_size_bits (l2_size_bits_r),
    .l2_way_bits  (l2_way_bits_r),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

endmodule

// ===== rtl/core/tlic_setix.sv =====
module tlic_setix import tlic_pkg::*; #(
  parameter int SETS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [TAG_W-1:0]  blk,
  input  logic [4:0]        size_bits,
  input  logic [2:0]        way_bits,
  input  logic [3:0]        offset_bits,
  output logic              done,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] idx
);

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

  logic signed [7:0] sb;
  logic [32:0]       mask_w;
  logic [31:0]       masked;

  always_comb begin
    sb = $signed({3'b0, size_bits}) - $signed({5'b0, way_bits})
       - $signed({4'b0, offset_bits});
    mask_w = (33'd1 << sb[5:0]) - 33'd1;
    if (sb <= 8'sd0) begin
      masked = '0;
    end else if (sb >= 8'sd32) begin
      masked = blk;
    end else begin
      masked = blk & mask_w[31:0];
    end
  end

  generate
    if (POW2) begin : g_mask
      logic          done_r;
      logic [SW-1:0] idx_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= go;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          idx_r <= (SETS > 1) ? masked[SW-1:0] : '0;
        end
      end

      assign done = done_r;
      assign idx  = idx_r;
    end else begin : g_rcp
      // quotient estimate by reciprocal is exact or one low; one subtract fixes it
      localparam int L = $clog2(SETS);
      localparam logic [63:0] RCP64 = (64'd1 << (31 + L)) / 64'(SETS);
      localparam logic [31:0] RCP   = RCP64[31:0];
      localparam logic [31:0] MOD   = 32'(SETS);

      logic          p0_r;
      logic          p1_r;
      logic          p2_r;
      logic          done_r;
      logic [31:0]   val_r;
      logic [63:0]   prod_r;
      logic [31:0]   rem_r;
      logic [SW-1:0] idx_r;
      logic [63:0]   quo_w;
      logic [31:0]   quo;
      logic [31:0]   qm;
      logic [31:0]   fix;

      always_comb begin
        quo_w = prod_r >> (31 + L);
        quo   = quo_w[31:0];
        qm    = quo * MOD;
        fix   = (rem_r >= MOD) ? (rem_r - MOD) : rem_r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          p0_r   <= 1'b0;
          p1_r   <= 1'b0;
          p2_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          p0_r   <= go;
          p1_r   <= p0_r;
          p2_r   <= p1_r;
          done_r <= p2_r;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          val_r <= masked;
        end
        if (p0_r) begin
          prod_r <= 64'(val_r) * 64'(RCP);
        end
        if (p1_r) begin
          rem_r <= val_r - qm;
        end
        if (p2_r) begin
          idx_r <= fix[SW-1:0];
        end
      end

      assign done = done_r;
      assign idx  = idx_r;
    end
  endgenerate

endmodule

// ===== rtl/core/tlic_level.sv =====
module tlic_level import tlic_pkg::*; #(
  parameter int SETS = 64,
  parameter int WAYS = 8,
  parameter int AW   = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       way_bits,
  input  logic             rd_en,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] rd_set,
  input  logic [TAG_W-1:0] key,
  input  logic             dirty_val,
  input  lvl_op_t          op,
  output lvl_st_t          st
);

  localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NA  = 1 << AW;

  typedef struct packed {
    logic [WAYS-1:0]            vld;
    logic [WAYS-1:0]            drt;
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0][AW-1:0]    age;
  } row_t;

  row_t          mem [SETS];
  logic          row_ok_r [SETS];
  row_t          row_r;
  logic          rvld_r;
  logic [SW-1:0] set_r;

  row_t            rst_row;
  row_t            cur;
  row_t            nr;
  logic [WAYS-1:0] en;
  logic [WAYS-1:0] hitv;
  logic [WAYS-1:0] invv;
  logic [WAYS-1:0] maxv;
  logic [NA-1:0]   present;
  logic [AW-1:0]   maxa;
  logic [WIW-1:0]  hw;
  logic [WIW-1:0]  iw;
  logic [WIW-1:0]  mw;
  logic [WIW-1:0]  way;
  logic [AW-1:0]   ta;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rst_row.vld[w] = 1'b0;
      rst_row.drt[w] = 1'b0;
      rst_row.tag[w] = '0;
      rst_row.age[w] = AW'(w);
      en[w] = ((6'(w) >> way_bits) == 6'd0);
    end
  end

  assign cur = rvld_r ? row_r : rst_row;

  always_comb begin
    present = '0;
    for (int w = 0; w < WAYS; w++) begin
      hitv[w] = en[w] & cur.vld[w] & (cur.tag[w] == key);
      invv[w] = en[w] & ~cur.vld[w];
      if (en[w]) begin
        present[cur.age[w]] = 1'b1;
      end
    end
  end

  always_comb begin
    maxa = '0;
    for (int v = 0; v < NA; v++) begin
      if (present[v]) begin
        maxa = AW'(v);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      maxv[w] = en[w] & (cur.age[w] == maxa);
    end
  end

  always_comb begin
    hw = '0;
    iw = '0;
    mw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) hw = WIW'(w);
      if (invv[w]) iw = WIW'(w);
      if (maxv[w]) mw = WIW'(w);
    end
    priority if (|hitv) begin
      way = hw;
    end else if (|invv) begin
      way = iw;
    end else begin
      way = mw;
    end
  end

  assign st.hit       = |hitv;
  assign st.vic_valid = cur.vld[way];
  assign st.vic_dirty = cur.drt[way];
  assign st.vic_tag   = cur.tag[way];

  always_comb begin
    nr = cur;
    ta = cur.age[way];
    if (op.fill) begin
      nr.vld[way] = 1'b1;
      nr.tag[way] = key;
      nr.drt[way] = dirty_val;
    end
    if (op.inval) begin
      nr.vld[way] = 1'b0;
      nr.drt[way] = 1'b0;
    end
    if (op.dirty_we) begin
      nr.drt[way] = dirty_val;
    end
    if (op.touch) begin
      for (int w = 0; w < WAYS; w++) begin
        if (en[w] && nr.vld[w] && (cur.age[w] < ta)) begin
          nr.age[w] = cur.age[w] + AW'(1);
        end
      end
      nr.age[way] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.we) begin
      mem[set_r] <= nr;
    end
    if (rd_en) begin
      row_r <= mem[rd_set];
      set_r <= rd_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        row_ok_r[s] <= 1'b0;
      end
      rvld_r <= 1'b0;
    end else begin
      if (op.we) begin
        row_ok_r[set_r] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= row_ok_r[rd_set];
      end
    end
  end

endmodule

// ===== rtl/core/tlic_dp.sv =====
module tlic_dp import tlic_pkg::*; #(
  parameter int L1_SETS = 64,
  parameter int L1_WAYS = 8,
  parameter int L2_SETS = 256,
  parameter int L2_WAYS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic [3:0] offset_bits,
  input  logic [4:0] l1_size_bits,
  input  logic [1:0] l1_way_bits,
  input  logic [4:0] l2_size_bits,
  input  logic [2:0] l2_way_bits,
  input  ctrl_cmd_t  cmd,
  output ctrl_st_t   st,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int S1W = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int S2W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;

  logic [TAG_W-1:0] blk_r;
  logic             wr_r;
  logic [S1W-1:0]   s1_r;
  logic [TAG_W-1:0] old_r;
  logic [TAG_W-1:0] vb_r;
  logic             h2_r;
  logic             ev_r;
  logic             wb_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic [S1W-1:0]   sx1_idx;
  logic [S2W-1:0]   sx2_idx;
  logic [TAG_W-1:0] sx1_key;
  logic [TAG_W-1:0] sx2_key;
  logic [TAG_W-1:0] l1_key;
  logic [TAG_W-1:0] l2_key;
  logic [S1W-1:0]   l1_set;
  lvl_op_t          l1_op;

  assign sx1_key = cmd.sx1_key_old ? old_r : blk_r;
  assign sx2_key = cmd.sx2_key_vb ? vb_r : blk_r;
  assign l1_key  = cmd.l1_key_old ? old_r : blk_r;
  assign l2_key  = cmd.l2_key_vb ? vb_r : blk_r;
  assign l1_set  = cmd.l1_rd_s1 ? s1_r : sx1_idx;

  always_comb begin
    l1_op = cmd.l1_op;
    l1_op.dirty_we = cmd.l1_op.dirty_we & (wr_r == CMD_WRITE);
  end

  tlic_setix #(.SETS(L1_SETS)) u_sx1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (cmd.sx1_go),
    .blk         (sx1_key),
    .size_bits   (l1_size_bits),
    .way_bits    ({1'b0, l1_way_bits}),
    .offset_bits (offset_bits),
    .done        (st.sx1_done),
    .idx         (sx1_idx)
  );

  tlic_setix #(.SETS(L2_SETS)) u_sx2 (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (cmd.sx2_go),
    .blk         (sx2_key),
    .size_bits   (l2_size_bits),
    .way_bits    (l2_way_bits),
    .offset_bits (offset_bits),
    .done        (st.sx2_done),
    .idx         (sx2_idx)
  );

  tlic_level #(.SETS(L1_SETS), .WAYS(L1_WAYS), .AW(L1_AGE_W)) u_l1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .way_bits  ({1'b0, l1_way_bits}),
    .rd_en     (cmd.l1_rd),
    .rd_set    (l1_set),
    .key       (l1_key),
    .dirty_val (wr_r),
    .op        (l1_op),
    .st        (st.l1)
  );

  tlic_level #(.SETS(L2_SETS), .WAYS(L2_WAYS), .AW(L2_AGE_W)) u_l2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .way_bits  (l2_way_bits),
    .rd_en     (cmd.l2_rd),
    .rd_set    (sx2_idx),
    .key       (l2_key),
    .dirty_val (1'b0),
    .op        (cmd.l2_op),
    .st        (st.l2)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      blk_r <= in_item.address >> offset_bits;
      wr_r  <= in_item.cmd;
    end
    if (cmd.cap_s1) begin
      s1_r <= sx1_idx;
    end
    if (cmd.set_ev) begin
      old_r <= st.l2.vic_tag;
    end
    if (cmd.set_wb) begin
      vb_r <= st.l1.vic_tag;
    end
    if (cmd.finish) begin
      out_item_r.l1_hit             <= cmd.finish_hit;
      out_item_r.l2_hit             <= h2_r;
      out_item_r.l1_dirty_writeback <= wb_r;
      out_item_r.l2_valid_eviction  <= ev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_r        <= 1'b0;
      ev_r        <= 1'b0;
      wb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.accept) begin
        h2_r <= 1'b0;
        ev_r <= 1'b0;
        wb_r <= 1'b0;
      end else begin
        if (cmd.set_h2) h2_r <= 1'b1;
        if (cmd.set_ev) ev_r <= 1'b1;
        if (cmd.set_wb) wb_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/tlic_ctrl.sv =====
module tlic_ctrl import tlic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ctrl_st_t  st,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_X1, S_W1, S_P1, S_W2, S_P2, S_X3, S_W3,
    S_PI, S_R1B, S_P1B, S_X4, S_W4, S_P4, S_F1
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_X1;
        end
      end
      S_X1: begin
        cmd.sx1_go = 1'b1;
        state_nxt  = S_W1;
      end
      S_W1: begin
        if (st.sx1_done) begin
          cmd.cap_s1 = 1'b1;
          cmd.l1_rd  = 1'b1;
          state_nxt  = S_P1;
        end
      end
      S_P1: begin
        if (st.l1.hit) begin
          cmd.l1_op.we       = 1'b1;
          cmd.l1_op.dirty_we = 1'b1;
          cmd.l1_op.touch    = 1'b1;
          cmd.finish         = 1'b1;
          cmd.finish_hit     = 1'b1;
          state_nxt          = S_IDLE;
        end else begin
          cmd.sx2_go = 1'b1;
          state_nxt  = S_W2;
        end
      end
      S_W2: begin
        if (st.sx2_done) begin
          cmd.l2_rd = 1'b1;
          state_nxt = S_P2;
        end
      end
      S_P2: begin
        cmd.l2_op.we    = 1'b1;
        cmd.l2_op.touch = 1'b1;
        if (st.l2.hit) begin
          cmd.set_h2 = 1'b1;
          state_nxt  = S_R1B;
        end else begin
          cmd.l2_op.fill = 1'b1;
          if (st.l2.vic_valid) begin
            cmd.set_ev = 1'b1;
            state_nxt  = S_X3;
          end else begin
            state_nxt = S_R1B;
          end
        end
      end
      S_X3: begin
        cmd.sx1_go      = 1'b1;
        cmd.sx1_key_old = 1'b1;
        state_nxt       = S_W3;
      end
      S_W3: begin
        if (st.sx1_done) begin
          cmd.l1_rd = 1'b1;
          state_nxt = S_PI;
        end
      end
      S_PI: begin
        cmd.l1_key_old = 1'b1;
        if (st.l1.hit) begin
          cmd.l1_op.we    = 1'b1;
          cmd.l1_op.inval = 1'b1;
        end
        state_nxt = S_R1B;
      end
      S_R1B: begin
        cmd.l1_rd    = 1'b1;
        cmd.l1_rd_s1 = 1'b1;
        state_nxt    = S_P1B;
      end
      S_P1B: begin
        if (st.l1.vic_valid && st.l1.vic_dirty) begin
          cmd.set_wb = 1'b1;
          state_nxt  = S_X4;
        end else begin
          cmd.l1_op.we    = 1'b1;
          cmd.l1_op.fill  = 1'b1;
          cmd.l1_op.touch = 1'b1;
          cmd.finish      = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_X4: begin
        cmd.sx2_go     = 1'b1;
        cmd.sx2_key_vb = 1'b1;
        state_nxt      = S_W4;
      end
      S_W4: begin
        if (st.sx2_done) begin
          cmd.l2_rd = 1'b1;
          state_nxt = S_P4;
        end
      end
      S_P4: begin
        cmd.l2_key_vb = 1'b1;
        if (st.l2.hit) begin
          cmd.l2_op.we    = 1'b1;
          cmd.l2_op.touch = 1'b1;
        end
        state_nxt = S_F1;
      end
      S_F1: begin
        cmd.l1_op.we    = 1'b1;
        cmd.l1_op.fill  = 1'b1;
        cmd.l1_op.touch = 1'b1;
        cmd.finish      = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== sim/two_level_inclusive_lru_cache_tb.sv =====
module two_level_inclusive_lru_cache_tb;
  import tlic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int L1S = 64, L1W = 8, L2S = 256, L2W = 16;

  class cache_scoreboard;
    bit          v1[L1S*L1W];
    bit          d1[L1S*L1W];
    logic [31:0] t1[L1S*L1W];
    int unsigned a1[L1S*L1W];
    bit          v2[L2S*L2W];
    logic [31:0] t2[L2S*L2W];
    int unsigned a2[L2S*L2W];
    int unsigned offs, s1b, w1b, s2b, w2b;
    out_item_t   pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < L1S*L1W; i++) begin
        v1[i] = 0; d1[i] = 0; t1[i] = 0; a1[i] = i % L1W;
      end
      for (int i = 0; i < L2S*L2W; i++) begin
        v2[i] = 0; t2[i] = 0; a2[i] = i % L2W;
      end
      offs = 4; s1b = 10; w1b = 2; s2b = 14; w2b = 3;
    endfunction

    function void set_reg(logic [2:0] idx, logic [4:0] val);
      case (idx)
        CFG_OFFSET_BITS:  offs = val[3:0];
        CFG_L1_SIZE_BITS: s1b = val;
        CFG_L1_WAY_BITS:  w1b = val[1:0];
        CFG_L2_SIZE_BITS: s2b = val;
        CFG_L2_WAY_BITS:  w2b = val[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned nways(bit lv);
      int unsigned n;
      n = lv ? (1 << w2b) : (1 << w1b);
      if (lv) return n > L2W ? L2W : n;
      return n > L1W ? L1W : n;
    endfunction

    function int unsigned set_of(bit lv, logic [31:0] blk);
      int sb;
      logic [31:0] m;
      sb = lv ? int'(s2b) - int'(w2b) - int'(offs) : int'(s1b) - int'(w1b) - int'(offs);
      if (sb <= 0) m = 0;
      else if (sb >= 32) m = '1;
      else m = (32'd1 << sb) - 1;
      return (blk & m) % (lv ? L2S : L1S);
    endfunction

    function bit lookup(bit lv, int unsigned s, logic [31:0] blk, output int unsigned way);
      int unsigned n, b, best;
      n = nways(lv); b = s * (lv ? L2W : L1W); best = 0;
      for (int w = 0; w < n; w++)
        if ((lv ? v2[b+w] : v1[b+w]) && (lv ? t2[b+w] : t1[b+w]) == blk) begin
          way = w; return 1;
        end
      for (int w = 0; w < n; w++)
        if (!(lv ? v2[b+w] : v1[b+w])) begin
          way = w; return 0;
        end
      for (int w = 1; w < n; w++)
        if ((lv ? a2[b+w] : a1[b+w]) > (lv ? a2[b+best] : a1[b+best])) best = w;
      way = best;
      return 0;
    endfunction

    function void refresh(bit lv, int unsigned s, int unsigned way);
      int unsigned n, b, ag;
      n = nways(lv);
      if (lv) begin
        b = s * L2W; ag = a2[b+way];
        for (int w = 0; w < n; w++) if (v2[b+w] && a2[b+w] < ag) a2[b+w]++;
        a2[b+way] = 0;
      end else begin
        b = s * L1W; ag = a1[b+way];
        for (int w = 0; w < n; w++) if (v1[b+w] && a1[b+w] < ag) a1[b+w]++;
        a1[b+way] = 0;
      end
    endfunction

    function void note_access(in_item_t it);
      logic [31:0] blk, old;
      int unsigned s1, s2, w1, w2, so, wo, i1, i2;
      bit h2;
      out_item_t r;
      r = '0;
      blk = it.address >> offs;
      s1 = set_of(0, blk);
      if (lookup(0, s1, blk, w1)) begin
        if (it.cmd == CMD_WRITE) d1[s1*L1W+w1] = 1;
        refresh(0, s1, w1);
        r.l1_hit = 1;
        pending.push_back(r);
        return;
      end
      s2 = set_of(1, blk);
      h2 = lookup(1, s2, blk, w2);
      i2 = s2 * L2W + w2;
      if (!h2) begin
        if (v2[i2]) begin
          old = t2[i2];
          so = set_of(0, old);
          r.l2_valid_eviction = 1;
          if (lookup(0, so, old, wo)) begin
            v1[so*L1W+wo] = 0; d1[so*L1W+wo] = 0;
          end
        end
        v2[i2] = 1; t2[i2] = blk;
      end
      refresh(1, s2, w2);
      void'(lookup(0, s1, blk, w1));
      i1 = s1 * L1W + w1;
      if (v1[i1] && d1[i1]) begin
        old = t1[i1];
        so = set_of(1, old);
        r.l1_dirty_writeback = 1;
        if (lookup(1, so, old, wo)) refresh(1, so, wo);
        d1[i1] = 0;
      end
      if (it.cmd == CMD_WRITE) d1[i1] = 1;
      v1[i1] = 1; t1[i1] = blk;
      refresh(0, s1, w1);
      r.l2_hit = h2;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %b", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %b actual %b", exp, got);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid, cfg_wr_en;
  in_item_t in_item;
  out_item_t out_item;
  logic [2:0] cfg_index;
  logic [4:0] cfg_wdata;
  cache_scoreboard sb;
  int idle_cycles;
  bit quiet;

  two_level_inclusive_lru_cache dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
    if (rst_n && ((start && !busy) || out_valid || cfg_wr_en)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("two_level_inclusive_lru_cache_tb: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_wr_en <= 0;
  endtask

  task automatic set_geometry(int o, int a, int b, int c, int d);
    wait_drained();
    write_reg(CFG_OFFSET_BITS, 5'(o));
    write_reg(CFG_L1_SIZE_BITS, 5'(a));
    write_reg(CFG_L1_WAY_BITS, 5'(b));
    write_reg(CFG_L2_SIZE_BITS, 5'(c));
    write_reg(CFG_L2_WAY_BITS, 5'(d));
  endtask

  task automatic send(logic [31:0] addr, logic cmd);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_item.address <= addr;
    in_item.cmd <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_access('{address: addr, cmd: cmd});
    start <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n, int spread);
    logic [31:0] base, a;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) a = $urandom;
      else a = base + ($urandom_range(0, spread) << $urandom_range(0, 8));
      send(a, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    idle_cycles = 0; quiet = 0;
    rst_n = 0; start = 0; in_item = '0; cfg_wr_en = 0; cfg_index = '0; cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(32'h0, 1'b0); send(32'h0, 1'b1); send(32'hFFFF_FFFF, 1'b1);
    send(32'hFFFF_FFF0, 1'b0);
    for (int i = 0; i < 12; i++) send(i << 10, i[0]);
    for (int i = 0; i < 6; i++) send(i << 14, 1'b1);
    send(32'h0, 1'b0); send(32'hAAAA_5555, 1'b1); send(32'h5555_AAAA, 1'b0);
    random_phase(400, 4095);
    wait_drained();
    random_phase(300, 255);
    set_geometry(15, 31, 3, 31, 7);
    random_phase(250, 65535);
    set_geometry(0, 0, 0, 0, 0);
    random_phase(150, 15);
    set_geometry(2, 6, 1, 9, 2);
    random_phase(400, 255);
    set_geometry(8, 20, 3, 24, 4);
    random_phase(200, 4095);
    quiet = 1;
    set_geometry(4, 10, 2, 14, 3);
    random_phase(200, 1023);
    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("two_level_inclusive_lru_cache_tb: PASS");
    else
      $display("two_level_inclusive_lru_cache_tb: FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/tlic_pkg.sv
rtl/core/tlic_setix.sv
rtl/core/tlic_level.sv
rtl/core/tlic_dp.sv
rtl/core/tlic_ctrl.sv
rtl/core/two_level_inclusive_lru_cache.sv
sim/two_level_inclusive_lru_cache_tb.sv
